>>> design/gfi_pkg.sv
// ----------------------------------------------------------------------------
// gfi_pkg: shared types and constants for the gap fill interpolator
// Payload structs, method codes and the front-to-back command word.
// ----------------------------------------------------------------------------
package gfi_pkg;

  localparam int unsigned PendingDepth = 32;
  localparam int unsigned ValueBits    = 48;
  localparam int unsigned TagBits      = 32;
  localparam int unsigned CntBits      = $clog2(PendingDepth + 1);
  localparam int unsigned IdxBits      = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
  localparam int unsigned CfgIdxBits   = 1;
  localparam int unsigned CfgDataBits  = 2;
  localparam int unsigned QueueDepth   = 2;

  // wide enough for |new - last| and i*r products
  localparam int unsigned MagBits = ValueBits + 1;

  localparam logic [CfgIdxBits-1:0] CfgFillMethod = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgBypass     = 1'b1;

  localparam logic [1:0] MethodForward  = 2'd0;
  localparam logic [1:0] MethodBackward = 2'd1;

  typedef struct packed {
    logic                        kind;
    logic                        sample_null;
    logic signed [ValueBits-1:0] sample_value;
    logic [TagBits-1:0]          row_tag;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] out_value;
    logic                        out_null;
    logic [TagBits-1:0]          out_tag;
    logic                        overflow_fill;
    logic                        last_of_run;
  } out_item_t;

  // work the back end carries out
  typedef enum logic [2:0] {
    OpEmit  = 3'b001,  // single word, no buffer walk
    OpFill  = 3'b010,  // walk buffer toward new value, then emit the sample
    OpDrain = 3'b100   // walk buffer with last value or null
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic signed [ValueBits-1:0] value;
    logic                        is_null;
    logic [TagBits-1:0]          tag;
    logic                        ovf;
    logic                        linear;   // fill uses interpolation
    logic [CntBits-1:0]          count;    // entries to walk
    logic [IdxBits-1:0]          base;     // buffer start slot
    logic signed [ValueBits-1:0] last;
    logic                        have_last;
    logic                        last_word; // emit word ends this input
  } cmd_t;

endpackage

>>> design/gap_fill_interpolator.sv
// ----------------------------------------------------------------------------
// gap_fill_interpolator: fills null samples in a tagged value stream
// A plain word passes the command queue and the back end StLast state into the
// output register. A gap closure runs the linear divide (one quotient bit per
// cycle) when it interpolates, then reads and emits each buffered word in turn.
// The back end walk machine takes a new command only while it is idle.
// Reset: fill_method linear, bypass off, buffer empty, no last value.
// ----------------------------------------------------------------------------
module gap_fill_interpolator import gfi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_data_o
);

  logic               f_valid, f_stall, q_valid, q_stall, buf_we, busy;
  cmd_t               f_cmd, q_cmd;
  logic [IdxBits-1:0] buf_waddr;
  logic [TagBits-1:0] buf_wdata;

  gfi_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_stall_i(f_stall), .cmd_o(f_cmd),
    .buf_we_o(buf_we), .buf_waddr_o(buf_waddr), .buf_wdata_o(buf_wdata),
    .walk_busy_i(busy)
  );

  gfi_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_stall_o(f_stall), .push_data_i(f_cmd),
    .pop_valid_o(q_valid), .pop_stall_i(q_stall), .pop_data_o(q_cmd)
  );

  gfi_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_stall_o(q_stall), .cmd_i(q_cmd),
    .buf_we_i(buf_we), .buf_waddr_i(buf_waddr), .buf_wdata_i(buf_wdata),
    .walk_busy_o(busy),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

>>> design/gfi_front.sv
// ----------------------------------------------------------------------------
// gfi_front: input classifier
// Tracks fill state, writes null tags to the pending buffer, issues commands.
// ----------------------------------------------------------------------------
module gfi_front import gfi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_data_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_stall_i,
  output cmd_t                   cmd_o,
  output logic                   buf_we_o,
  output logic [IdxBits-1:0]     buf_waddr_o,
  output logic [TagBits-1:0]     buf_wdata_o,
  input  logic                   walk_busy_i
);

  logic [1:0]                  method_q;
  logic                        bypass_q;
  logic [CntBits-1:0]          count_q, count_d;
  logic [IdxBits-1:0]          head_q, head_d;
  logic signed [ValueBits-1:0] last_q, last_d;
  logic                        have_q, have_d;
  logic                        acc;
  logic [IdxBits-1:0]          wslot;
  logic                        full;
  // second word of an overflow null: buffer after the drain
  logic                        ovf_pend_q, ovf_pend_d;
  logic [TagBits-1:0]          ovf_tag_q;

  // buffer writes must wait while the back end still reads older entries
  assign full = (count_q == CntBits'(PendingDepth));
  assign acc  = in_valid_i && !in_stall_o;
  assign in_stall_o = cmd_stall_i || ovf_pend_q ||
                      (walk_busy_i && !in_data_i.kind && in_data_i.sample_null);

  always_comb begin
    logic [IdxBits:0] sum;
    sum   = {1'b0, head_q} + (IdxBits+1)'(count_q);
    wslot = (sum >= (IdxBits+1)'(PendingDepth)) ?
            IdxBits'(sum - (IdxBits+1)'(PendingDepth)) : sum[IdxBits-1:0];
  end

  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    last_d      = last_q;
    have_d      = have_q;
    ovf_pend_d  = 1'b0;
    cmd_valid_o = 1'b0;
    buf_we_o    = 1'b0;
    buf_waddr_o = wslot;
    buf_wdata_o = in_data_i.row_tag;
    cmd_o           = '0;
    cmd_o.op        = OpEmit;
    cmd_o.value     = in_data_i.sample_value;
    cmd_o.is_null   = in_data_i.sample_null;
    cmd_o.tag       = in_data_i.row_tag;
    cmd_o.count     = count_q;
    cmd_o.base      = head_q;
    cmd_o.last      = last_q;
    cmd_o.have_last = have_q;
    cmd_o.linear    = (method_q != MethodBackward);
    cmd_o.last_word = 1'b1;
    if (ovf_pend_q) begin
      // buffer is empty now, head already moved
      buf_we_o    = !walk_busy_i;
      buf_waddr_o = head_q;
      buf_wdata_o = ovf_tag_q;
      ovf_pend_d  = walk_busy_i;
      if (!walk_busy_i) count_d = CntBits'(1);
    end else if (acc) begin
      priority if (in_data_i.kind) begin
        cmd_valid_o = (count_q != '0);
        cmd_o.op    = OpDrain;
        count_d     = '0;
        head_d      = wslot;
      end else if (bypass_q) begin
        cmd_valid_o = 1'b1;
      end else if (in_data_i.sample_null) begin
        if (method_q == MethodForward) begin
          cmd_valid_o   = 1'b1;
          cmd_o.is_null = !have_q;
          cmd_o.value   = have_q ? last_q : '0;
        end else if (full) begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = OpDrain;
          cmd_o.ovf   = 1'b1;
          count_d     = '0;
          head_d      = wslot;
          ovf_pend_d  = 1'b1;
        end else begin
          buf_we_o = 1'b1;
          count_d  = count_q + CntBits'(1);
        end
      end else begin
        cmd_valid_o = 1'b1;
        cmd_o.op    = OpFill;
        count_d     = '0;
        head_d      = wslot;
        last_d      = in_data_i.sample_value;
        have_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q   <= 2'd2;
      bypass_q   <= 1'b0;
      count_q    <= '0;
      head_q     <= '0;
      last_q     <= '0;
      have_q     <= 1'b0;
      ovf_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFillMethod: method_q <= cfg_data_i;
          CfgBypass:     bypass_q <= cfg_data_i[0];
          default:       ;
        endcase
      end
      count_q    <= count_d;
      head_q     <= head_d;
      last_q     <= last_d;
      have_q     <= have_d;
      ovf_pend_q <= ovf_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) ovf_tag_q <= in_data_i.row_tag;
  end

endmodule

>>> design/gfi_queue.sv
// ----------------------------------------------------------------------------
// gfi_queue: short command queue between front and back
// Two-entry register queue; decouples the stall of each side.
// ----------------------------------------------------------------------------
module gfi_queue import gfi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_stall_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_stall_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  cmd_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [PtrBits:0]   fill_q;
  logic               push, pop;

  assign push_stall_o = (fill_q == (PtrBits+1)'(QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && !pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + PtrBits'(1);
      if (pop)  rptr_q <= rptr_q + PtrBits'(1);
      fill_q <= fill_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

>>> design/gfi_divider.sv
// ----------------------------------------------------------------------------
// gfi_divider: radix-2 restoring divider
// Unsigned MagBits by count divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gfi_divider import gfi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MagBits-1:0] num_i,
  input  logic [CntBits:0]   den_i,
  output logic               done_o,
  output logic [MagBits-1:0] quo_o,
  output logic [CntBits:0]   rem_o
);

  localparam int unsigned StepBits = $clog2(MagBits + 1);

  logic [MagBits-1:0]  quo_q;
  logic [CntBits:0]    rem_q, den_q;
  logic [StepBits-1:0] step_q;
  logic                busy_q;
  logic [CntBits+1:0]  trial;

  assign trial  = {rem_q, quo_q[MagBits-1]} - {1'b0, den_q};
  assign done_o = busy_q && (step_q == '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepBits'(MagBits);
    end else if (busy_q) begin
      if (step_q == '0) busy_q <= 1'b0;
      else              step_q <= step_q - StepBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && step_q != '0) begin
      if (!trial[CntBits+1]) begin
        rem_q <= trial[CntBits:0];
        quo_q <= {quo_q[MagBits-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CntBits-1:0], quo_q[MagBits-1]};
        quo_q <= {quo_q[MagBits-2:0], 1'b0};
      end
    end
  end

endmodule

>>> design/gfi_back.sv
// ----------------------------------------------------------------------------
// gfi_back: result generator
// Owns the pending tag memory, walks it and emits result words.
// ----------------------------------------------------------------------------
module gfi_back import gfi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_stall_o,
  input  cmd_t               cmd_i,
  input  logic               buf_we_i,
  input  logic [IdxBits-1:0] buf_waddr_i,
  input  logic [TagBits-1:0] buf_wdata_i,
  output logic               walk_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StRead = 5'b00100,
    StEmit = 5'b01000,
    StLast = 5'b10000
  } state_e;

  logic [TagBits-1:0] mem_q [PendingDepth];
  logic [TagBits-1:0] rtag_q;

  state_e               st_q, st_d;
  cmd_t                 cmd_q;
  logic [CntBits-1:0]   idx_q;   // entries emitted so far
  logic [IdxBits-1:0]   raddr_q;
  logic                 up_q;
  logic [MagBits-1:0]   mq_q;
  logic [CntBits:0]     mr_q;
  // running i*q and i*r with r-part kept below den
  logic [MagBits-1:0]   acc_q;
  logic [CntBits:0]     racc_q;
  logic [MagBits-1:0]   acc_n;
  logic [CntBits+1:0]   rsum;
  logic [CntBits:0]     racc_n;
  logic [CntBits:0]     den;
  logic [MagBits-1:0]   div_num;
  logic [CntBits:0]     div_den;
  logic signed [MagBits-1:0] nw_x, ls_x;
  logic signed [MagBits-1:0] nw_i, ls_i;
  logic                 div_start, div_done;
  logic [MagBits-1:0]   div_q;
  logic [CntBits:0]     div_r;
  logic                 out_v_q;
  out_item_t            out_q;
  logic                 out_free;
  logic                 take;
  logic signed [ValueBits-1:0] fill_val;

  assign out_free    = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign cmd_stall_o = (st_q != StIdle);
  assign take        = cmd_valid_i && (st_q == StIdle);
  assign walk_busy_o = (st_q != StIdle) || cmd_valid_i;

  assign den  = (CntBits+1)'(cmd_q.count) + (CntBits+1)'(1);
  assign nw_x = MagBits'(cmd_q.value);
  assign ls_x = MagBits'(cmd_q.last);

  // divider operands come straight from the incoming command
  assign nw_i    = MagBits'(cmd_i.value);
  assign ls_i    = MagBits'(cmd_i.last);
  assign div_num = (nw_i >= ls_i) ? MagBits'(nw_i - ls_i) : MagBits'(ls_i - nw_i);
  assign div_den = (CntBits+1)'(cmd_i.count) + (CntBits+1)'(1);

  assign rsum   = {1'b0, racc_q} + {1'b0, mr_q};
  assign racc_n = (rsum >= {1'b0, den}) ? (CntBits+1)'(rsum - {1'b0, den}) : rsum[CntBits:0];
  assign acc_n  = acc_q + mq_q + MagBits'(rsum >= {1'b0, den});

  always_comb begin
    logic [MagBits-1:0] step;
    step = acc_n;
    if (cmd_q.op == OpDrain)
      fill_val = cmd_q.last;
    else if (!cmd_q.linear || !cmd_q.have_last)
      fill_val = cmd_q.value;
    else if (up_q)
      fill_val = ValueBits'(ls_x + $signed(step));
    else
      fill_val = ValueBits'(ls_x - $signed(step));
  end

  gfi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_q),
    .rem_o  (div_r)
  );

  always_comb begin
    st_d      = st_q;
    div_start = 1'b0;
    unique case (st_q)
      StIdle: if (take) begin
        if (cmd_i.op == OpEmit || cmd_i.count == '0) st_d = StLast;
        else st_d = StDiv;
      end
      StDiv: begin
        // divider was kicked at take; a linear fill waits for it, other walks go straight to the reads
        if (cmd_q.op == OpFill && cmd_q.linear && cmd_q.have_last) begin
          if (div_done) st_d = StRead;
        end else begin
          st_d = StRead;
        end
      end
      StRead: st_d = StEmit;
      StEmit: if (out_free) begin
        if (idx_q + CntBits'(1) == cmd_q.count)
          st_d = (cmd_q.op == OpFill) ? StLast : StIdle;
        else
          st_d = StRead;
      end
      StLast: if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
    if (take && !(cmd_i.op == OpEmit || cmd_i.count == '0)) div_start = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (buf_we_i) mem_q[buf_waddr_i] <= buf_wdata_i;
    rtag_q <= mem_q[raddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_free) out_v_q <= 1'b0;
      if ((st_q == StEmit || st_q == StLast) && out_free) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q   <= cmd_i;
      idx_q   <= '0;
      raddr_q <= cmd_i.base;
      acc_q   <= '0;
      racc_q  <= '0;
    end
    if (st_q == StDiv) begin
      up_q <= (nw_x >= ls_x);
      mq_q <= div_q;
      mr_q <= div_r;
    end
    if (st_q == StEmit && out_free) begin
      out_q.out_value     <= cmd_q.op == OpDrain && !cmd_q.have_last ? '0 : fill_val;
      out_q.out_null      <= cmd_q.op == OpDrain && !cmd_q.have_last;
      out_q.out_tag       <= rtag_q;
      out_q.overflow_fill <= cmd_q.ovf;
      out_q.last_of_run   <= (cmd_q.op == OpDrain) && (idx_q + CntBits'(1) == cmd_q.count);
      idx_q   <= idx_q + CntBits'(1);
      raddr_q <= (raddr_q == IdxBits'(PendingDepth - 1)) ? '0 : raddr_q + IdxBits'(1);
      acc_q   <= acc_n;
      racc_q  <= racc_n;
    end
    if (st_q == StLast && out_free) begin
      out_q.out_value     <= cmd_q.is_null ? (cmd_q.value & {ValueBits{1'b0}}) | cmd_q.value
                                           : cmd_q.value;
      out_q.out_null      <= cmd_q.is_null;
      out_q.out_tag       <= cmd_q.tag;
      out_q.overflow_fill <= 1'b0;
      out_q.last_of_run   <= 1'b1;
    end
  end

  property p_walk_starts_idle;
    @(posedge clk_i) disable iff (!rst_ni) take |=> (st_q != StIdle);
  endproperty
  a_walk_starts_idle: assert property (p_walk_starts_idle) else $error("walk not started");

  property p_out_held;
    @(posedge clk_i) disable iff (!rst_ni) (out_v_q && out_stall_i) |=> out_v_q;
  endproperty
  a_out_held: assert property (p_out_held) else $error("result dropped");

  property p_idx_bound;
    @(posedge clk_i) disable iff (!rst_ni) (st_q == StEmit) |-> (idx_q < cmd_q.count);
  endproperty
  a_idx_bound: assert property (p_idx_bound) else $error("walk past buffer");

endmodule
